[src/emrt_pkg.sv]
package emrt_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_ROUTES_DEF = 64;
   localparam int PORT_BITS_DEF  = 8;

   // Fixed field widths
   localparam int ADDR_BITS = 32;
   localparam int KIND_BITS = 2;

   // Request kinds; the high bit alone selects lookup
   localparam logic [KIND_BITS-1:0] REQ_ADD    = 2'd0;
   localparam logic [KIND_BITS-1:0] REQ_REMOVE = 2'd1;

   typedef enum logic [2:0] {
      STS_ADDED       = 3'd0,
      STS_UPDATED     = 3'd1,
      STS_UNCHANGED   = 3'd2,
      STS_REMOVED     = 3'd3,
      STS_REMOVE_MISS = 3'd4,
      STS_LOOKUP_HIT  = 3'd5,
      STS_LOOKUP_MISS = 3'd6,
      STS_FULL        = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DRAIN,
      SEQ_DECIDE
   } seq_state_type;

endpackage

[src/emrt_if.sv]
// Request channel: add, remove or lookup
interface emrt_req_if #(parameter int PORT_BITS = emrt_pkg::PORT_BITS_DEF) ();
   import emrt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] req_type;
   logic [ADDR_BITS-1:0] dest_addr;
   logic [PORT_BITS-1:0] out_port;

   modport source (output valid, req_type, dest_addr, out_port, input ready);
   modport sink   (input valid, req_type, dest_addr, out_port, output ready);
endinterface

// Response channel: one per request
interface emrt_rsp_if #(parameter int PORT_BITS = emrt_pkg::PORT_BITS_DEF) ();
   import emrt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [PORT_BITS-1:0] found_port;
   status_type           status;

   modport source (output valid, hit, found_port, status, input ready);
   modport sink   (input valid, hit, found_port, status, output ready);
endinterface

[src/emrt_ram.sv]
module emrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/emrt_match.sv]
module emrt_match #(
   parameter int MAX_ROUTES = emrt_pkg::MAX_ROUTES_DEF,
   parameter int PORT_BITS  = emrt_pkg::PORT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          start,
   input  logic                          pend,
   input  logic [$clog2(MAX_ROUTES)-1:0] pend_idx,
   input  logic [emrt_pkg::ADDR_BITS+PORT_BITS:0] entry,
   input  logic [emrt_pkg::ADDR_BITS-1:0] key_addr,
   output logic                          match_found,
   output logic [$clog2(MAX_ROUTES)-1:0] match_idx,
   output logic [PORT_BITS-1:0]          match_port,
   output logic                          free_found,
   output logic [$clog2(MAX_ROUTES)-1:0] free_idx
);
   import emrt_pkg::*;

   localparam int IDX_W  = $clog2(MAX_ROUTES);
   localparam int WORD_W = 1 + ADDR_BITS + PORT_BITS;

   logic                 ent_valid;
   logic [ADDR_BITS-1:0] ent_addr;
   logic [PORT_BITS-1:0] ent_port;
   logic                 is_match;
   logic                 is_free;

   logic                 match_found_ff, match_found_in;
   logic [IDX_W-1:0]     match_idx_ff, match_idx_in;
   logic [PORT_BITS-1:0] match_port_ff, match_port_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;

   // Unpack the entry word read from the table
   assign ent_valid = entry[WORD_W-1];
   assign ent_addr  = entry[PORT_BITS +: ADDR_BITS];
   assign ent_port  = entry[PORT_BITS-1:0];

   // Shared compare: one entry per cycle
   assign is_match = pend && ent_valid && (ent_addr == key_addr);
   assign is_free  = pend && !ent_valid;

   // Keep the first match and the lowest free slot
   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_port_in  = match_port_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      if (start) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
      end else begin
         if (is_match && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = pend_idx;
            match_port_in  = ent_port;
         end
         if (is_free && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = pend_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_port_ff  <= match_port_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
   end

   assign match_found = match_found_ff;
   assign match_idx   = match_idx_ff;
   assign match_port  = match_port_ff;
   assign free_found  = free_found_ff;
   assign free_idx    = free_idx_ff;

endmodule

[src/exact_match_route_table.sv]
// Channel | Dir | Signals                                  | Transfer
// req     | in  | valid ready req_type dest_addr out_port  | valid && ready
// rsp     | out | valid ready hit found_port status        | valid && ready
//
// From acceptance, each request passes SCAN, DRAIN and DECIDE before the registered response goes valid:
// the table RAM read port scans one entry per cycle into the compare unit.
// After reset a clearing pass writes every entry invalid,
// with req.ready low. A response waiting on rsp.ready does not block the
// next request's scan; only its final write-back waits for the output register.
module exact_match_route_table #(
   parameter int MAX_ROUTES = emrt_pkg::MAX_ROUTES_DEF,
   parameter int PORT_BITS  = emrt_pkg::PORT_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   emrt_req_if.sink   req,
   emrt_rsp_if.source rsp
);
   import emrt_pkg::*;

   localparam int IDX_W  = $clog2(MAX_ROUTES);
   localparam int WORD_W = 1 + ADDR_BITS + PORT_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ROUTES - 1);

   seq_state_type        state_ff, state_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff;

   logic [KIND_BITS-1:0] kind_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [PORT_BITS-1:0] port_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 hit_ff, hit_in;
   logic [PORT_BITS-1:0] fport_ff, fport_in;
   status_type           status_ff, status_in;

   logic                 accept;
   logic                 fire;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic [WORD_W-1:0]    rd_data;

   logic                 match_found;
   logic [IDX_W-1:0]     match_idx;
   logic [PORT_BITS-1:0] match_port;
   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;

   assign req.ready = (state_ff == SEQ_IDLE);
   assign accept    = req.valid && req.ready;
   assign fire      = (state_ff == SEQ_DECIDE) && (!rsp_valid_ff || rsp.ready);

   // Table storage: {valid, address, port}
   emrt_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROUTES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // Compare unit fed one entry per cycle
   emrt_match #(.MAX_ROUTES(MAX_ROUTES), .PORT_BITS(PORT_BITS)) u_match (
      .clock       (clock),
      .start       (accept),
      .pend        (pend_ff),
      .pend_idx    (pend_idx_ff),
      .entry       (rd_data),
      .key_addr    (addr_ff),
      .match_found (match_found),
      .match_idx   (match_idx),
      .match_port  (match_port),
      .free_found  (free_found),
      .free_idx    (free_idx)
   );

   // Sequencer: clear, idle, scan, drain, decide
   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      pend_in  = 1'b0;
      case (state_ff)
         SEQ_CLEAR: begin
            if (ptr_ff == LAST_IDX) begin
               state_in = SEQ_IDLE;
               ptr_in   = '0;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         SEQ_IDLE: begin
            ptr_in = '0;
            if (accept) begin
               state_in = SEQ_SCAN;
            end
         end
         SEQ_SCAN: begin
            pend_in = 1'b1;
            if (ptr_ff == LAST_IDX) begin
               state_in = SEQ_DRAIN;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         SEQ_DRAIN: begin
            state_in = SEQ_DECIDE;
         end
         SEQ_DECIDE: begin
            if (fire) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Outcome and write-back
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = ptr_ff;
      wr_data   = '0;
      hit_in    = 1'b0;
      fport_in  = '0;
      status_in = STS_LOOKUP_MISS;
      case (kind_ff)
         REQ_ADD: begin
            if (match_found) begin
               hit_in = 1'b1;
               if (match_port != port_ff) begin
                  wr_en     = fire;
                  wr_addr   = match_idx;
                  wr_data   = {1'b1, addr_ff, port_ff};
                  status_in = STS_UPDATED;
               end else begin
                  status_in = STS_UNCHANGED;
               end
            end else if (free_found) begin
               wr_en     = fire;
               wr_addr   = free_idx;
               wr_data   = {1'b1, addr_ff, port_ff};
               status_in = STS_ADDED;
            end else begin
               status_in = STS_FULL;
            end
         end
         REQ_REMOVE: begin
            if (match_found && (match_port == port_ff)) begin
               wr_en     = fire;
               wr_addr   = match_idx;
               wr_data   = {1'b0, addr_ff, port_ff};
               hit_in    = 1'b1;
               status_in = STS_REMOVED;
            end else begin
               status_in = STS_REMOVE_MISS;
            end
         end
         default: begin
            // lookup
            if (match_found) begin
               hit_in    = 1'b1;
               fport_in  = match_port;
               status_in = STS_LOOKUP_HIT;
            end
         end
      endcase
      // Clearing pass owns the write port
      if (state_ff == SEQ_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff;
         wr_data = '0;
      end
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_CLEAR;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= ptr_ff;
      if (accept) begin
         kind_ff <= req.req_type;
         addr_ff <= req.dest_addr;
         port_ff <= req.out_port;
      end
      if (fire) begin
         hit_ff    <= hit_in;
         fport_ff  <= fport_in;
         status_ff <= status_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hit        = hit_ff;
   assign rsp.found_port = fport_ff;
   assign rsp.status     = status_ff;

endmodule

[src/emrt_checker.sv]
module emrt_checker #(
   parameter int PORT_BITS = emrt_pkg::PORT_BITS_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_hit,
   input logic [PORT_BITS-1:0] rsp_found_port,
   input logic [2:0]           rsp_status
);
   import emrt_pkg::*;

   // A stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Block is busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while scan in progress");

   // Hit flag agrees with status
   a_hit_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_UPDATED || rsp_status == STS_UNCHANGED ||
                    rsp_status == STS_REMOVED || rsp_status == STS_LOOKUP_HIT)
      |-> rsp_hit)
      else $error("hit missing for a matching status");

   a_hit_clr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_ADDED || rsp_status == STS_FULL ||
                    rsp_status == STS_REMOVE_MISS || rsp_status == STS_LOOKUP_MISS)
      |-> !rsp_hit)
      else $error("hit set for a missing status");

   // Port only reported on a lookup hit
   a_port_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_LOOKUP_HIT) |-> (rsp_found_port == '0))
      else $error("found_port nonzero outside lookup hit");

endmodule

bind exact_match_route_table emrt_checker #(.PORT_BITS(PORT_BITS)) u_emrt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_hit        (rsp.hit),
   .rsp_found_port (rsp.found_port),
   .rsp_status     (rsp.status)
);
